// ===== rtl/core/indexed_list_store_macros.svh =====
// assertion macros for the indexed list store
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every clock while out of reset
`define ILS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("indexed_list_store assertion failed");
// consequent holds in the clock after the antecedent
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_list_store assertion failed");
`else
`define ILS_ASSERT(lbl, clk, rst_n, prop)
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ils_pkg.sv =====
`default_nettype none

package ils_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_GET    = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // one finished result
    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   answer;
        logic [ECNT_W-1:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/ils_ram.sv =====
`default_nettype none

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ils_seq.sv =====
`default_nettype none

module ils_seq #(
    parameter int CAPACITY = 16,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [ils_pkg::POS_W-1:0]  i_position,
    input  wire logic [ils_pkg::VAL_W-1:0]  i_item_value,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output ils_pkg::t_result                o_res,
    output logic                            o_ram_we,
    output logic [AW-1:0]                   o_ram_waddr,
    output logic [ils_pkg::VAL_W-1:0]       o_ram_wdata,
    output logic [AW-1:0]                   o_ram_raddr,
    input  wire logic [ils_pkg::VAL_W-1:0]  i_ram_rdata
);

    import ils_pkg::*;

    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_CMP,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx,   n_idx;
    t_req              r_req,   n_req;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [VAL_W-1:0]  r_val,   n_val;
    t_status           r_status, n_status;
    logic [VAL_W-1:0]  r_answer, n_answer;

    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     pos_c;
    logic [XW-1:0]     in_pos_x;
    logic [XW-1:0]     cnt_x;

    // shared index step and compare
    assign idx_inc  = r_idx + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign pos_c    = CW'(r_pos);
    assign in_pos_x = XW'(i_position);
    assign cnt_x    = XW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_req       = r_req;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_answer    = r_answer;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = r_val;
        o_ram_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = t_req'(i_req_type);
                    n_pos    = i_position;
                    n_val    = i_item_value;
                    n_status = ST_DONE;
                    n_answer = '0;
                    n_state  = S_RD;
                    case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            n_idx = r_count;
                            if (in_pos_x > cnt_x) begin
                                n_status = ST_MISS;
                                n_state  = S_DONE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end
                        end
                        REQ_SEARCH: begin
                            n_idx = '0;
                        end
                        default: begin
                            // delete and get
                            n_idx = CW'(i_position);
                            if (in_pos_x >= cnt_x) begin
                                n_status = ST_MISS;
                                n_state  = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                case (r_req)
                    REQ_INSERT: begin
                        if (r_idx == pos_c) begin
                            o_ram_we = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_state  = S_DONE;
                        end else begin
                            o_ram_raddr = idx_dec[AW-1:0];
                            n_state     = S_WR;
                        end
                    end
                    REQ_DELETE: begin
                        if (idx_inc == r_count) begin
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end else begin
                            o_ram_raddr = idx_inc[AW-1:0];
                            n_state     = S_WR;
                        end
                    end
                    REQ_SEARCH: begin
                        if (r_idx == r_count) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    default: begin
                        n_state = S_CMP;
                    end
                endcase
            end
            S_WR: begin
                // move the neighbor word into the current slot
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata;
                n_idx       = (r_req == REQ_INSERT) ? idx_dec : idx_inc;
                n_state     = S_RD;
            end
            S_CMP: begin
                if (r_req == REQ_SEARCH) begin
                    if (i_ram_rdata == r_val) begin
                        n_answer = VAL_W'(r_idx);
                        n_state  = S_DONE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end
                end else begin
                    n_answer = i_ram_rdata;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_req    <= n_req;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_answer <= n_answer;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.answer      = r_answer;
    assign o_res.entry_count = ECNT_W'(r_count);

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_store.sv =====
// channel   | valid        | ready        | payload
// ----------+--------------+--------------+-------------------------------------
// request   | i_req_valid  | o_req_ready  | i_req_type, i_position, i_item_value
// response  | o_rsp_valid  | i_rsp_ready  | o_status, o_answer, o_entry_count
//
// one request at a time; entries live in a single-port-write ram with registered read,
// and the sequencer moves or compares one word at a time, reading it in S_RD and then
// copying it in S_WR or checking it in S_CMP; a refused request skips to S_DONE
// synchronous active-low reset clears the count and the control; ram contents are not cleared
// a stalled response sits in the output register while the next request is already taken

`default_nettype none

`include "indexed_list_store_macros.svh"

module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [ils_pkg::POS_W-1:0]  i_position,
    input  wire logic signed [ils_pkg::VAL_W-1:0] i_item_value,
    output logic                            o_rsp_valid,
    input  wire logic                       i_rsp_ready,
    output logic [ils_pkg::STAT_W-1:0]      o_status,
    output logic signed [ils_pkg::VAL_W-1:0] o_answer,
    output logic [ils_pkg::ECNT_W-1:0]      o_entry_count
);

    import ils_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // sequencer to output register
    logic              seq_valid;
    logic              seq_ready;
    t_result           seq_res;

    // sequencer to entry ram
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    // output register
    logic              r_rsp_valid;
    t_result           r_rsp;

    // offered response flags for the checks below
    logic              rsp_full;
    logic              rsp_refused;

    ils_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_res_valid  (seq_valid),
        .i_res_ready  (seq_ready),
        .o_res        (seq_res),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    // list entries, words at positions 0 to count-1
    ils_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the register takes a new response when empty or being drained
    assign seq_ready = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (seq_valid && seq_ready) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_valid && seq_ready) begin
            r_rsp <= seq_res;
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_status      = r_rsp.status;
    assign o_answer      = r_rsp.answer;
    assign o_entry_count = r_rsp.entry_count;

    assign rsp_full    = o_rsp_valid && (o_status == ST_FULL);
    assign rsp_refused = o_rsp_valid && (o_status != ST_DONE);

    // the count never runs past the capacity
    `ILS_ASSERT(a_count_bound, i_clk, i_rst_n, !o_rsp_valid || (int'(o_entry_count) <= CAPACITY))
    // a full refusal only comes with a full list
    `ILS_ASSERT(a_full_count, i_clk, i_rst_n, !rsp_full || (o_entry_count == ECNT_W'(CAPACITY)))
    // refused or missed requests carry a zero answer
    `ILS_ASSERT(a_miss_zero, i_clk, i_rst_n, !rsp_refused || (o_answer == '0))
    // a taken request keeps the sequencer busy for the next cycle
    `ILS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready)

endmodule

`default_nettype wire
